### sv/hyperbolic_threshold_shrink_unit_defines.svh
// Assertion macros for the hyperbolic threshold shrink unit.
// Used by the top level only.
`ifndef HYPERBOLIC_THRESHOLD_SHRINK_UNIT_DEFINES_SVH
`define HYPERBOLIC_THRESHOLD_SHRINK_UNIT_DEFINES_SVH
// assert that a condition implies another on the same edge
`define HTS_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// assert that a condition implies another on the next edge
`define HTS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

### sv/hts_pkg.sv
// Types and constants for the hyperbolic threshold shrink unit.
// No dependencies.
package hts_pkg;
   localparam int SampleWidth = 16;
   localparam int RootWidth   = 16;
   localparam int RadWidth    = 32;
   localparam logic [14:0] SatMax = 15'h7fff;
   localparam logic CsrFrameLength    = 1'b0;
   localparam logic CsrThresholdScale = 1'b1;
   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef struct packed {
      logic            start;
      logic [RadWidth-1:0] radicand;
   } sqrt_req_type;
   typedef struct packed {
      logic            done;
      logic [RootWidth-1:0] root;
   } sqrt_rsp_type;
endpackage

### sv/hyperbolic_threshold_shrink_unit.sv
// Hyperbolic threshold shrink unit: top level.
// Depends on hts_pkg, hts_sqrt and hyperbolic_threshold_shrink_unit_defines.svh.
//
// Usage: configure frame_length (csr index 0) and threshold_scale (index 1)
// while idle. Feed coefficients on req_; each word is taken in one cycle
// into a MAX_FRAME-entry coefficient memory while a frame loads. After
// the last word of a frame the block stops taking input and runs its
// noise pass: a read state and an accumulate state for each window entry,
// a 45-step serial divide by the window size, a 2-stage multiply by
// threshold_scale, then for each coefficient one memory read, a bit-serial
// square root (skipped when nothing is left under it) and one output word.
// Outputs appear on rsp_ with rsp_frame_end on the last word; a stalled
// receiver holds the output register and the pass waits. Reset clears the
// load count and all control state; memory contents need no reset.
// A frame_length below 4 acts as 4 and one above MAX_FRAME as MAX_FRAME.
`include "hyperbolic_threshold_shrink_unit_defines.svh"
module hyperbolic_threshold_shrink_unit #(
   parameter int MAX_FRAME = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample_out,
   output logic               rsp_frame_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [19:0]        csr_data
);
   localparam int AW = $clog2(MAX_FRAME);
   localparam logic [6:0] MaxLen = 7'(MAX_FRAME);

   localparam logic [3:0] StLoad = 4'd0;
   localparam logic [3:0] StSumRd = 4'd1;
   localparam logic [3:0] StSumAcc = 4'd2;
   localparam logic [3:0] StVar = 4'd3;
   localparam logic [3:0] StDiv = 4'd4;
   localparam logic [3:0] StMul = 4'd5;
   localparam logic [3:0] StMul2 = 4'd6;
   localparam logic [3:0] StOutRd = 4'd7;
   localparam logic [3:0] StSqStart = 4'd8;
   localparam logic [3:0] StSqWait = 4'd9;
   localparam logic [3:0] StEmit = 4'd10;

   logic [AW-1:0] rd_addr;
   hts_pkg::sample_type mem [MAX_FRAME];
   hts_pkg::sample_type rd_data_ff;

   logic [3:0]  state_ff, state_in;
   logic [6:0]  len_ff, len_in;
   logic [19:0] scale_ff, scale_in;
   logic [6:0]  load_ff, load_in;
   logic [6:0]  n_ff, n_in;
   logic [6:0]  idx_ff, idx_in;
   logic [6:0]  m_ff, m_in;
   logic signed [22:0] sum_ff, sum_in;
   logic [37:0] sq_ff, sq_in;
   logic [44:0] num_ff, num_in;
   logic [38:0] quo_ff, quo_in;
   logic [6:0]  drem_ff, drem_in;
   logic [6:0]  dcnt_ff, dcnt_in;
   logic [57:0] prod_ff, prod_in;
   logic [39:0] delta_ff, delta_in;
   logic [31:0] xsq_ff, xsq_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_ff, out_in;
   logic        end_ff, end_in;

   logic [6:0]  n_eff;
   logic [6:0]  load_next;
   logic signed [31:0] x_sq_s;
   logic [22:0] s_abs;
   logic [45:0] s_sq;
   logic [44:0] mq;
   logic [7:0]  dtrial;
   logic [14:0] r_sat;
   hts_pkg::sqrt_req_type sq_req;
   hts_pkg::sqrt_rsp_type sq_rsp;

   hts_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sq_req), .rsp(sq_rsp));

   assign n_eff = (len_ff < 7'd4) ? 7'd4 : ((len_ff > MaxLen) ? MaxLen : len_ff);
   assign load_next = load_ff + 7'd1;
   assign req_ready = (state_ff == StLoad);
   assign csr_ready = 1'b1;
   assign x_sq_s = 32'(rd_data_ff) * 32'(rd_data_ff);
   assign s_abs = sum_ff[22] ? 23'(-sum_ff) : 23'(sum_ff);
   assign s_sq = 46'(s_abs) * 46'(s_abs);
   assign mq = 45'(m_ff) * 45'(sq_ff);
   assign dtrial = {drem_ff, num_ff[44]};
   assign r_sat = sq_rsp.root[15] ? hts_pkg::SatMax : sq_rsp.root[14:0];

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      scale_in = scale_ff;
      load_in = load_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      m_in = m_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      drem_in = drem_ff;
      dcnt_in = dcnt_ff;
      prod_in = prod_ff;
      delta_in = delta_ff;
      xsq_in = xsq_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in = out_ff;
      end_in = end_ff;
      rd_addr = idx_ff[AW-1:0];
      sq_req.start = 1'b0;
      sq_req.radicand = xsq_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         unique case (csr_index[0])
            hts_pkg::CsrFrameLength:    len_in = csr_data[6:0];
            hts_pkg::CsrThresholdScale: scale_in = csr_data;
            default: ;
         endcase
      end
      unique case (state_ff)
         StLoad: begin
            if (req_valid) begin
               if (load_next >= n_eff) begin
                  load_in = '0;
                  n_in = n_eff;
                  m_in = 7'((n_eff >> 1) + 7'd1);
                  idx_in = 7'(n_eff - 7'((n_eff >> 1) + 7'd1));
                  sum_in = '0;
                  sq_in = '0;
                  state_in = StSumRd;
               end else begin
                  load_in = load_next;
               end
            end
         end
         StSumRd: begin
            state_in = StSumAcc;
         end
         StSumAcc: begin
            sum_in = sum_ff + 23'(rd_data_ff);
            sq_in = sq_ff + 38'(unsigned'(x_sq_s));
            idx_in = idx_ff + 7'd1;
            state_in = (idx_ff + 7'd1 == n_ff) ? StVar : StSumRd;
         end
         StVar: begin
            num_in = 45'(mq - 45'(s_sq));
            drem_in = '0;
            quo_in = '0;
            dcnt_in = '0;
            state_in = StDiv;
         end
         StDiv: begin
            num_in = {num_ff[43:0], 1'b0};
            if (dtrial >= {1'b0, m_ff}) begin
               drem_in = 7'(dtrial - {1'b0, m_ff});
               quo_in = {quo_ff[37:0], 1'b1};
            end else begin
               drem_in = dtrial[6:0];
               quo_in = {quo_ff[37:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd44) state_in = StMul;
         end
         StMul: begin
            prod_in = 58'(quo_ff) * 58'(scale_ff);
            state_in = StMul2;
         end
         StMul2: begin
            delta_in = prod_ff[57:18];
            idx_in = '0;
            state_in = StOutRd;
         end
         StOutRd: begin
            state_in = StSqStart;
         end
         StSqStart: begin
            if (40'(unsigned'(x_sq_s)) > delta_ff) begin
               xsq_in = 32'(40'(unsigned'(x_sq_s)) - delta_ff);
            end else begin
               xsq_in = '0;
            end
            state_in = StSqWait;
         end
         StSqWait: begin
            sq_req.start = (xsq_ff != '0) && !sq_rsp.done && (dcnt_ff != 7'd0);
            dcnt_in = 7'd0;
            if (xsq_ff == '0 || sq_rsp.done) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (xsq_ff == '0 || rd_data_ff == 16'sd0) begin
                  out_in = '0;
               end else if (rd_data_ff[15]) begin
                  out_in = 16'(-$signed({1'b0, r_sat}));
               end else begin
                  out_in = {1'b0, r_sat};
               end
               end_in = (idx_ff + 7'd1 == n_ff);
               idx_in = idx_ff + 7'd1;
               dcnt_in = 7'd1;
               state_in = (idx_ff + 7'd1 == n_ff) ? StLoad : StOutRd;
            end
         end
         default: state_in = StLoad;
      endcase
      if (state_ff == StSqStart) begin
         dcnt_in = 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StLoad && req_valid) begin
         mem[load_ff[AW-1:0]] <= req_sample_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         len_ff <= 7'd64;
         scale_ff <= 20'd30548;
         load_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         scale_ff <= scale_in;
         load_ff <= load_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff <= dcnt_in;
      end
      n_ff <= n_in;
      idx_ff <= idx_in;
      m_ff <= m_in;
      sum_ff <= sum_in;
      sq_ff <= sq_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      drem_ff <= drem_in;
      prod_ff <= prod_in;
      delta_ff <= delta_in;
      xsq_ff <= xsq_in;
      out_ff <= out_in;
      end_ff <= end_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_ff;
   assign rsp_frame_end = end_ff;

   `HTS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out), "output word changed while stalled")
   `HTS_ASSERT_IMPL(a_load, clock, reset, req_ready, load_ff < MaxLen, "load count out of range")
   `HTS_ASSERT_IMPL(a_sat, clock, reset, rsp_valid, rsp_sample_out != 16'sh8000, "output not saturated")
endmodule

### sv/hts_sqrt.sv
// Bit-serial integer square root, one result bit per cycle for a 16-bit root.
// Depends on hts_pkg.
module hts_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  hts_pkg::sqrt_req_type req,
   output hts_pkg::sqrt_rsp_type rsp
);
   logic [hts_pkg::RadWidth-1:0]  rem_ff, rem_in;
   logic [hts_pkg::RootWidth-1:0] root_ff, root_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [hts_pkg::RadWidth+1:0]  part;
   logic [hts_pkg::RadWidth+1:0]  trial;
   logic [hts_pkg::RadWidth-1:0]  rad_ff, rad_in;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rad_in  = rad_ff;
      done_in = 1'b0;
      part    = {rem_ff, rad_ff[hts_pkg::RadWidth-1 -: 2]};
      trial   = {{(hts_pkg::RadWidth-hts_pkg::RootWidth){1'b0}}, root_ff, 2'b01};
      if (req.start) begin
         rem_in  = '0;
         root_in = '0;
         rad_in  = req.radicand;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[hts_pkg::RadWidth-3:0], 2'b00};
         if (part >= trial) begin
            rem_in  = hts_pkg::RadWidth'(part - trial);
            root_in = {root_ff[hts_pkg::RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = hts_pkg::RadWidth'(part);
            root_in = {root_ff[hts_pkg::RootWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;
endmodule

### bench/testbench.sv
// Self-checking bench for the hyperbolic threshold shrink unit: frames of
// directed and random coefficients against a built-in shrink predictor.
// Depends on hts_pkg and hyperbolic_threshold_shrink_unit.
module testbench;
   localparam int MaxFrame = 64;
   localparam longint CycleLimit = 3000000;

   typedef struct {
      hts_pkg::sample_type sample;
      logic                last;
   } shrunk_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hts_pkg::sample_type req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hts_pkg::sample_type rsp_sample_out;
   logic rsp_frame_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [19:0] csr_data = '0;

   hyperbolic_threshold_shrink_unit #(.MAX_FRAME(MaxFrame)) DUT (.*);

   always #2 clock = ~clock;

   logic [6:0]  frame_length_reg;
   logic [19:0] scale_reg;
   hts_pkg::sample_type coef_mem [MaxFrame];
   logic [6:0]  fill_count;
   shrunk_word_type shrunk_queue [$];
   int   failures = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   longint cycle_count = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic int active_length();
      int n = frame_length_reg;
      if (n < 4) n = 4;
      if (n > MaxFrame) n = MaxFrame;
      return n;
   endfunction

   function automatic void shrink_frame_predict(hts_pkg::sample_type x);
      int n = active_length();
      int win, first;
      longint s = 0;
      longint unsigned q = 0, ss, dev, delta2, sq, r;
      longint v;
      shrunk_word_type w;
      coef_mem[fill_count[5:0]] = x;
      fill_count = fill_count + 7'd1;
      if (fill_count < n) return;
      fill_count = '0;
      win = n / 2 + 1;
      first = n - win;
      for (int i = first; i < n; i++) begin
         v = coef_mem[i];
         s += v;
         q += longint'(v * v);
      end
      ss = (s < 0) ? -s : s;
      dev = (longint'(win) * q - ss * ss) / longint'(win);
      delta2 = (dev * scale_reg) >> 18;
      for (int i = 0; i < n; i++) begin
         v = coef_mem[i];
         sq = v * v;
         r = (sq > delta2) ? int_sqrt(sq - delta2) : 0;
         if (r > 32767) r = 32767;
         w.sample = (v > 0) ? hts_pkg::sample_type'(r) :
                    (v < 0) ? hts_pkg::sample_type'(-longint'(r)) : '0;
         w.last = (i == n - 1);
         shrunk_queue = {shrunk_queue, w};
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) shrink_frame_predict(req_sample_in);
         if (rsp_valid && rsp_ready) begin
            if (shrunk_queue.size() == 0) begin
               $error("sample_out: no word expected, actual %0d", rsp_sample_out);
               failures++;
            end else begin
               if (rsp_sample_out !== shrunk_queue[0].sample) begin
                  $error("sample_out: expected %0d actual %0d",
                         shrunk_queue[0].sample, rsp_sample_out);
                  failures++;
               end
               if (rsp_frame_end !== shrunk_queue[0].last) begin
                  $error("frame_end: expected %0b actual %0b",
                         shrunk_queue[0].last, rsp_frame_end);
                  failures++;
               end
               void'(shrunk_queue.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_csr(logic [0:0] idx, logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == hts_pkg::CsrFrameLength) frame_length_reg = val[6:0];
      else scale_reg = val;
      @(posedge clock);
   endtask

   task automatic send_word(hts_pkg::sample_type x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shrunk_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic hts_pkg::sample_type random_coef(int mode);
      case (mode)
         0: return hts_pkg::sample_type'($urandom);
         1: return hts_pkg::sample_type'($urandom_range(400) - 200);
         default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   // directed words: expected output typed in where obvious, else predictor
   typedef struct {
      hts_pkg::sample_type x;
      logic                typed;
      hts_pkg::sample_type y;
   } row_type;
   row_type directed [] = '{
      '{16'sh7fff, 1, 16'sh7fff}, '{16'sh8000, 1, 16'sh8001},
      '{16'sh0000, 1, 16'sh0000}, '{16'sh0001, 1, 16'sh0001},
      '{16'sh7fff, 0, 0}, '{16'sh8000, 0, 0}, '{16'shffff, 0, 0},
      '{16'sh0100, 0, 0}, '{16'sh5555, 0, 0}, '{16'shaaaa, 0, 0},
      '{16'sh0000, 0, 0}, '{16'sh1234, 0, 0}
   };

   initial begin
      int n_items, n_len;
      frame_length_reg = 7'd64;
      scale_reg = 20'd30548;
      fill_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero scale: first frame passes through with only -32768 clipped
      write_csr(hts_pkg::CsrFrameLength, 20'd4);
      write_csr(hts_pkg::CsrThresholdScale, 20'd0);
      for (int i = 0; i < 4; i++) send_word(directed[i].x);
      req_valid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         if (shrunk_queue[i].sample !== directed[i].y) begin
            $error("sample_out: expected %0d actual %0d (table)",
                   directed[i].y, shrunk_queue[i].sample);
            failures++;
         end
      end
      drain();
      write_csr(hts_pkg::CsrFrameLength, 20'd8);
      write_csr(hts_pkg::CsrThresholdScale, 20'hfffff);
      for (int i = 4; i < directed.size(); i++) send_word(directed[i].x);
      drain();
      // out-of-range lengths and lowering mid-frame
      write_csr(hts_pkg::CsrFrameLength, 20'd0);
      write_csr(hts_pkg::CsrThresholdScale, 20'd30548);
      for (int i = 0; i < 4; i++) send_word(random_coef(0));
      drain();
      write_csr(hts_pkg::CsrFrameLength, 20'd127);
      for (int i = 0; i < 64; i++) send_word(random_coef(i % 3));
      drain();
      write_csr(hts_pkg::CsrFrameLength, 20'd10);
      for (int i = 0; i < 6; i++) send_word(random_coef(1));
      drain();
      write_csr(hts_pkg::CsrFrameLength, 20'd5);
      send_word(random_coef(0));
      drain();
      n_items = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 36 : 60) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 36 : 60) : 0;
         n_len = (ph == 0) ? 4 : $urandom_range(15, 4);
         write_csr(hts_pkg::CsrFrameLength, 20'(n_len));
         write_csr(hts_pkg::CsrThresholdScale,
                   (ph == 2) ? 20'hfffff : 20'($urandom_range(120000)));
         for (int k = 0; k < 65; k++) begin
            send_word(random_coef($urandom_range(2)));
            n_items++;
         end
         n_len = active_length();
         repeat ((n_len - (65 % n_len)) % n_len) send_word(random_coef(0));
         drain();
      end
      recv_stall_pct = 0;
      drain();
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
